@@ hdl/bnts_pkg.sv @@
`default_nettype none
package bnts_pkg;

	localparam int MAX_DIGITS_DEF = 8;
	localparam int DIGIT_BITS_DEF = 4;

	localparam int TUPLE_W   = 32;
	localparam int ORD_W     = 32;
	localparam int RADIX_W   = 5;
	localparam int LEN_W     = 4;
	localparam int CFG_IDX_W = 1;

	typedef logic [1:0] cmd_t;
	typedef logic [1:0] status_t;

	localparam cmd_t CMD_NEXT   = 2'd0;
	localparam cmd_t CMD_BACK   = 2'd1;
	localparam cmd_t CMD_UNRANK = 2'd2;
	localparam cmd_t CMD_PASS   = 2'd3;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_NO_NEXT = 2'd1;
	localparam status_t ST_NO_BACK = 2'd2;
	localparam status_t ST_RANGE   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_RADIX  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 1'b1;

	localparam logic [RADIX_W-1:0] RADIX_RESET  = 5'd2;
	localparam logic [LEN_W-1:0]   LENGTH_RESET = 4'd2;

	// floor(2^32 / n); entries for n < 2 are not used
	localparam logic [31:0] RECIP [32] = '{
		32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h5555_5555,
		32'h4000_0000, 32'h3333_3333, 32'h2AAA_AAAA, 32'h2492_4924,
		32'h2000_0000, 32'h1C71_C71C, 32'h1999_9999, 32'h1745_D174,
		32'h1555_5555, 32'h13B1_3B13, 32'h1249_2492, 32'h1111_1111,
		32'h1000_0000, 32'h0F0F_0F0F, 32'h0E38_E38E, 32'h0D79_435E,
		32'h0CCC_CCCC, 32'h0C30_C30C, 32'h0BA2_E8BA, 32'h0B21_642C,
		32'h0AAA_AAAA, 32'h0A3D_70A3, 32'h09D8_9D89, 32'h097B_425E,
		32'h0924_9249, 32'h08D3_DCB0, 32'h0888_8888, 32'h0842_1084
	};

	typedef struct packed {
		cmd_t    cmd;
		status_t status;
		logic    force_range;
	} bnts_ctl_t;

endpackage
`default_nettype wire

@@ hdl/base_n_tuple_stepper.sv @@
// Steps k-digit radix-n tuples (position 0 most significant) one word at a time.
// Slave stream: s_tuser = command (next, back, unrank, pass),
//   s_tdata = {ordinal, tuple_in}. Master stream: m_tdata = tuple_out,
//   m_tuser = status. Every accepted word gives exactly one result word, in order.
// cfg channel writes radix (index 0) and tuple_length (index 1); cfg_ready is
// always high. Write config only while the pipeline is empty.
// Pipeline stages: two front stages for digit checks and next/back rebuild,
// two stages per digit position for the unrank divide (reciprocal multiply,
// then remainder and correction), and the output register. Throughput: one
// word per cycle while m_tready does not stall the output.
// Each stage has its own valid bit and takes a new word when it is empty or
// its successor moves, so bubbles close up and a stalled m_tready holds the
// output word while upstream stages keep filling. s_tready drops only when
// every stage is full.
// Reset clears all valid bits and loads radix 2, tuple_length 2; s_tready is
// high straight out of reset.
`default_nettype none
module base_n_tuple_stepper #(
	parameter int MAX_DIGITS = bnts_pkg::MAX_DIGITS_DEF,
	parameter int DIGIT_BITS = bnts_pkg::DIGIT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [63:0]                      s_tdata,   // tuple_in, ordinal
	input  bnts_pkg::cmd_t                   s_tuser,   // command
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [31:0]                      m_tdata,   // tuple_out
	output bnts_pkg::status_t                m_tuser,   // status
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bnts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bnts_pkg::RADIX_W-1:0]     cfg_data
);
	import bnts_pkg::*;

	localparam int KW        = $clog2(MAX_DIGITS + 1);
	localparam int RADIX_CAP = 1 << DIGIT_BITS;

	logic [RADIX_W-1:0] radix_q;
	logic [LEN_W-1:0]   length_q;
	logic [RADIX_W-1:0] n_eff;
	logic [KW-1:0]      k_eff;
	logic [31:0]        recip;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= RADIX_RESET;
			length_q <= LENGTH_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RADIX:  radix_q  <= cfg_data;
				REG_LENGTH: length_q <= cfg_data[LEN_W-1:0];
				default:    ;
			endcase
		end
	end

	assign n_eff = (int'(radix_q) > RADIX_CAP) ? RADIX_W'(RADIX_CAP) : radix_q;
	assign k_eff = (int'(length_q) > MAX_DIGITS) ? KW'(MAX_DIGITS) : KW'(length_q);
	assign recip = RECIP[n_eff];

	logic               valid_c [MAX_DIGITS+1];
	logic               ready_c [MAX_DIGITS+1];
	bnts_ctl_t          ctl_c   [MAX_DIGITS+1];
	logic [TUPLE_W-1:0] tin_c   [MAX_DIGITS+1];
	logic [TUPLE_W-1:0] res_c   [MAX_DIGITS+1];
	logic [ORD_W-1:0]   x_c     [MAX_DIGITS+1];

	bnts_front #(
		.MAX_DIGITS (MAX_DIGITS),
		.DIGIT_BITS (DIGIT_BITS),
		.KW         (KW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.n         (n_eff),
		.k         (k_eff),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser),
		.in_tuple  (s_tdata[31:0]),
		.in_ord    (s_tdata[63:32]),
		.out_valid (valid_c[0]),
		.out_ready (ready_c[0]),
		.out_ctl   (ctl_c[0]),
		.out_tin   (tin_c[0]),
		.out_res   (res_c[0]),
		.out_x     (x_c[0])
	);

	for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_digit
		bnts_div #(
			.MAX_DIGITS (MAX_DIGITS),
			.DIGIT_BITS (DIGIT_BITS),
			.KW         (KW),
			.J          (g)
		) u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.n         (n_eff),
			.m         (recip),
			.k         (k_eff),
			.in_valid  (valid_c[g]),
			.in_ready  (ready_c[g]),
			.in_ctl    (ctl_c[g]),
			.in_tin    (tin_c[g]),
			.in_res    (res_c[g]),
			.in_x      (x_c[g]),
			.out_valid (valid_c[g+1]),
			.out_ready (ready_c[g+1]),
			.out_ctl   (ctl_c[g+1]),
			.out_tin   (tin_c[g+1]),
			.out_res   (res_c[g+1]),
			.out_x     (x_c[g+1])
		);
	end

	// output register; unrank range check is a nonzero leftover quotient or force_range
	logic               valid_q;
	logic [TUPLE_W-1:0] tuple_q;
	status_t            status_q;
	logic               range_err;

	assign ready_c[MAX_DIGITS] = !valid_q || m_tready;
	assign range_err = (x_c[MAX_DIGITS] != '0) || ctl_c[MAX_DIGITS].force_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_c[MAX_DIGITS]) begin
			valid_q <= valid_c[MAX_DIGITS];
		end
	end

	always_ff @(posedge clk) begin
		if (ready_c[MAX_DIGITS] && valid_c[MAX_DIGITS]) begin
			if (ctl_c[MAX_DIGITS].cmd == CMD_UNRANK && range_err) begin
				tuple_q  <= tin_c[MAX_DIGITS];
				status_q <= ST_RANGE;
			end else begin
				tuple_q  <= res_c[MAX_DIGITS];
				status_q <= ctl_c[MAX_DIGITS].status;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = tuple_q;
	assign m_tuser  = status_q;

endmodule
`default_nettype wire

@@ hdl/bnts_front.sv @@
`default_nettype none
module bnts_front #(
	parameter int MAX_DIGITS = bnts_pkg::MAX_DIGITS_DEF,
	parameter int DIGIT_BITS = bnts_pkg::DIGIT_BITS_DEF,
	parameter int KW         = $clog2(bnts_pkg::MAX_DIGITS_DEF + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [bnts_pkg::RADIX_W-1:0]   n,
	input  logic [KW-1:0]                  k,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  bnts_pkg::cmd_t                 in_cmd,
	input  logic [bnts_pkg::TUPLE_W-1:0]   in_tuple,
	input  logic [bnts_pkg::ORD_W-1:0]     in_ord,
	output logic                           out_valid,
	input  logic                           out_ready,
	output bnts_pkg::bnts_ctl_t            out_ctl,
	output logic [bnts_pkg::TUPLE_W-1:0]   out_tin,
	output logic [bnts_pkg::TUPLE_W-1:0]   out_res,
	output logic [bnts_pkg::ORD_W-1:0]     out_x
);
	import bnts_pkg::*;

	localparam int SW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	typedef logic [MAX_DIGITS-1:0][DIGIT_BITS-1:0] digits_t;

	function automatic digits_t unpack(input logic [TUPLE_W-1:0] t);
		digits_t d;
		d = '0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			for (int b = 0; b < DIGIT_BITS; b++) begin
				if (DIGIT_BITS * i + b < TUPLE_W) begin
					d[i][b] = t[DIGIT_BITS * i + b];
				end
			end
		end
		return d;
	endfunction

	function automatic logic [TUPLE_W-1:0] pack(input digits_t d);
		logic [TUPLE_W-1:0] t;
		t = '0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			for (int b = 0; b < DIGIT_BITS; b++) begin
				if (DIGIT_BITS * i + b < TUPLE_W) begin
					t[DIGIT_BITS * i + b] = d[i][b];
				end
			end
		end
		return t;
	endfunction

	// stage 1: digit checks
	logic                  valid_s1;
	cmd_t                  cmd_s1;
	logic [TUPLE_W-1:0]    tin_s1;
	logic [ORD_W-1:0]      ord_s1;
	logic                  ok_s1;
	logic [MAX_DIGITS-1:0] ltmax_s1;
	logic [MAX_DIGITS-1:0] nz_s1;

	logic                  ready_s1;
	logic                  ready_s2;

	digits_t               din;
	logic                  ok_c;
	logic [MAX_DIGITS-1:0] ltmax_c;
	logic [MAX_DIGITS-1:0] nz_c;

	assign ready_s2 = !out_valid || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_comb begin
		din     = unpack(in_tuple);
		ok_c    = 1'b1;
		ltmax_c = '0;
		nz_c    = '0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (i < int'(k)) begin
				if (n == '0 || 9'(din[i]) >= 9'(n)) begin
					ok_c = 1'b0;
				end
				ltmax_c[i] = (9'(din[i]) + 9'd1) < 9'(n);
				nz_c[i]    = (din[i] != '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			cmd_s1   <= in_cmd;
			tin_s1   <= in_tuple;
			ord_s1   <= in_ord;
			ok_s1    <= ok_c;
			ltmax_s1 <= ltmax_c;
			nz_s1    <= nz_c;
		end
	end

	// stage 2: pick the digit that moves and rebuild the tuple
	logic               found_nx;
	logic               found_bk;
	logic [SW-1:0]      sel_nx;
	logic [SW-1:0]      sel_bk;
	digits_t            d1;
	digits_t            nd_nx;
	digits_t            nd_bk;
	logic [TUPLE_W-1:0] res_c;
	status_t            st_c;
	bnts_ctl_t          ctl_c;

	always_comb begin
		found_nx = 1'b0;
		found_bk = 1'b0;
		sel_nx   = '0;
		sel_bk   = '0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (ltmax_s1[i]) begin
				found_nx = 1'b1;
				sel_nx   = SW'(i);
			end
			if (nz_s1[i]) begin
				found_bk = 1'b1;
				sel_bk   = SW'(i);
			end
		end
	end

	always_comb begin
		d1    = unpack(tin_s1);
		nd_nx = '0;
		nd_bk = '0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (i < int'(k)) begin
				if (i < int'(sel_nx)) begin
					nd_nx[i] = d1[i];
				end else if (i == int'(sel_nx)) begin
					nd_nx[i] = d1[i] + DIGIT_BITS'(1);
				end
				if (i < int'(sel_bk)) begin
					nd_bk[i] = d1[i];
				end else if (i == int'(sel_bk)) begin
					nd_bk[i] = d1[i] - DIGIT_BITS'(1);
				end else begin
					nd_bk[i] = DIGIT_BITS'(n - RADIX_W'(1));
				end
			end
		end
	end

	always_comb begin
		res_c = tin_s1;
		st_c  = ST_OK;
		unique case (cmd_s1)
			CMD_NEXT: begin
				if (ok_s1 && found_nx) begin
					res_c = pack(nd_nx);
				end else begin
					st_c = ST_NO_NEXT;
				end
			end
			CMD_BACK: begin
				if (ok_s1 && found_bk) begin
					res_c = pack(nd_bk);
				end else begin
					st_c = ST_NO_BACK;
				end
			end
			CMD_UNRANK: begin
				res_c = '0;
			end
			default: begin
				res_c = tin_s1;
			end
		endcase
		ctl_c.cmd         = cmd_s1;
		ctl_c.status      = st_c;
		ctl_c.force_range = (n == '0) && (k != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ready_s2) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			out_ctl <= ctl_c;
			out_tin <= tin_s1;
			out_res <= res_c;
			out_x   <= ord_s1;
		end
	end

endmodule
`default_nettype wire

@@ hdl/bnts_div.sv @@
`default_nettype none
module bnts_div #(
	parameter int MAX_DIGITS = bnts_pkg::MAX_DIGITS_DEF,
	parameter int DIGIT_BITS = bnts_pkg::DIGIT_BITS_DEF,
	parameter int KW         = $clog2(bnts_pkg::MAX_DIGITS_DEF + 1),
	parameter int J          = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [bnts_pkg::RADIX_W-1:0]   n,
	input  logic [31:0]                    m,
	input  logic [KW-1:0]                  k,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  bnts_pkg::bnts_ctl_t            in_ctl,
	input  logic [bnts_pkg::TUPLE_W-1:0]   in_tin,
	input  logic [bnts_pkg::TUPLE_W-1:0]   in_res,
	input  logic [bnts_pkg::ORD_W-1:0]     in_x,
	output logic                           out_valid,
	input  logic                           out_ready,
	output bnts_pkg::bnts_ctl_t            out_ctl,
	output logic [bnts_pkg::TUPLE_W-1:0]   out_tin,
	output logic [bnts_pkg::TUPLE_W-1:0]   out_res,
	output logic [bnts_pkg::ORD_W-1:0]     out_x
);
	import bnts_pkg::*;

	// stage 1: quotient estimate x * floor(2^32/n) >> 32, low by at most one
	logic               valid_s1;
	bnts_ctl_t          ctl_s1;
	logic [TUPLE_W-1:0] tin_s1;
	logic [TUPLE_W-1:0] res_s1;
	logic [ORD_W-1:0]   x_s1;
	logic [ORD_W-1:0]   q0_s1;

	logic               ready_s1;
	logic               ready_s2;
	logic [63:0]        prod;

	assign ready_s2 = !out_valid || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;
	assign prod     = 64'(in_x) * 64'(m);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			ctl_s1 <= in_ctl;
			tin_s1 <= in_tin;
			res_s1 <= in_res;
			x_s1   <= in_x;
			q0_s1  <= prod[63:32];
		end
	end

	// stage 2: remainder, one correction step, drop the digit in place
	logic [36:0]        qn;
	logic [ORD_W-1:0]   r0;
	logic               fix;
	logic               small_n;
	logic               act;
	logic [RADIX_W-1:0] digit;
	logic [ORD_W-1:0]   q;
	logic [KW-1:0]      pos;
	logic [7:0]         shamt;
	logic [TUPLE_W-1:0] res_c;
	logic [ORD_W-1:0]   x_c;

	always_comb begin
		qn      = 37'(q0_s1) * 37'(n);
		r0      = x_s1 - qn[31:0];
		fix     = r0 >= 32'(n);
		small_n = n < RADIX_W'(2);
		if (small_n) begin
			digit = '0;
			q     = x_s1;
		end else if (fix) begin
			digit = RADIX_W'(r0 - 32'(n));
			q     = q0_s1 + 32'd1;
		end else begin
			digit = RADIX_W'(r0);
			q     = q0_s1;
		end
		act   = (ctl_s1.cmd == CMD_UNRANK) && (J < int'(k));
		pos   = k - KW'(1) - KW'(J);
		shamt = 8'(DIGIT_BITS) * 8'(pos);
		res_c = act ? (res_s1 | (32'(digit) << shamt)) : res_s1;
		x_c   = act ? q : x_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ready_s2) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			out_ctl <= ctl_s1;
			out_tin <= tin_s1;
			out_res <= res_c;
			out_x   <= x_c;
		end
	end

endmodule
`default_nettype wire

@@ hdl/bnts_checker.sv @@
`default_nettype none
module bnts_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_tready,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [31:0]                      m_tdata,
	input wire bnts_pkg::status_t                m_tuser,
	input wire logic                             cfg_valid,
	input wire logic                             cfg_ready
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	// input side only backs up when the output is stalled
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("s_tready low without output stall");

	// config writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("cfg write refused");

	// nothing comes out the first cycle after reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !m_tvalid)
		else $error("output valid right after reset");

endmodule

bind base_n_tuple_stepper bnts_checker u_bnts_checker (.*);
`default_nettype wire
